### hw/rtl/dlle_pkg.sv
`timescale 1ns / 1ps

package dlle_pkg;

    localparam int KEY_W    = 32;
    localparam int OP_W     = 3;
    localparam int COUNT_W  = 6;

    // operation codes carried in the command field
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_INSERT    = 3'd0;
    localparam op_t OP_DEL_KEY   = 3'd1;
    localparam op_t OP_DEL_FIRST = 3'd2;
    localparam op_t OP_DEL_LAST  = 3'd3;
    localparam op_t OP_READ      = 3'd4;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_EMPTY,
        ST_FULL
    } status_t;

    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] key_out;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_WALK,
        S_UNLINK,
        S_RELEASE,
        S_READ,
        S_EMIT
    } state_t;

endpackage

### hw/rtl/doubly_linked_list_engine.sv
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// cmd      in   cmd_valid / cmd_stall  cmd_t  (op, key)
// rsp      out  rsp_valid / rsp_stall  rsp_t  (status, key_out, count, last)
//
// steps: insert passes through S_INS and S_EMIT; delete first or last through
//   S_UNLINK, S_RELEASE and S_EMIT; delete key walks from the head in S_WALK,
//   then unlinks as above when found; read out emits each element in S_READ.
//   the walk is set by the next_link ram, one registered read a cycle
// reset: rst_n clears control state at once; no clearing pass, the free chain
//   is formed by a fill mark over never-used slots
// stalls: cmd_stall is high while a command is in work; rsp_stall holds the
//   result register and pauses a read out walk in place

module doubly_linked_list_engine
    import dlle_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IW        = $clog2(CAPACITY);      // slot index width
    localparam int CW        = $clog2(CAPACITY + 1);  // element count width
    localparam int MEM_DEPTH = 1 << IW;

    // control state
    state_t          state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [IW-1:0]   free_head_reg, free_head_next;
    logic [CW-1:0]   fresh_reg, fresh_next;           // slots below this were ever allocated
    logic [CW-1:0]   count_reg, count_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // payload
    logic [IW-1:0]   node_reg, node_next;             // address of the word now on the ram outputs
    logic [IW-1:0]   walk_reg, walk_next;
    logic [KEY_W-1:0] key_reg, key_next;
    status_t         status_reg, status_next;
    rsp_t            rsp_reg, rsp_next;

    // ram ports
    logic [IW-1:0]    rd_addr;
    logic             key_we;
    logic [KEY_W-1:0] key_rd;
    logic             nxt_we, prv_we;
    logic [IW-1:0]    nxt_wa, nxt_wd, nxt_rd;
    logic [IW-1:0]    prv_wa, prv_wd, prv_rd;

    logic            accept;
    logic            rsp_free;
    logic            is_empty, is_full;
    logic            walk_last;
    logic            key_match;
    logic            is_fresh;
    logic [CW-1:0]   fresh_inc;

    dlle_ram #(.WIDTH(KEY_W), .DEPTH(MEM_DEPTH)) u_key_store
    (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (node_reg),
        .wr_data (key_reg),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    dlle_ram #(.WIDTH(IW), .DEPTH(MEM_DEPTH)) u_next_link
    (
        .clk     (clk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_wa),
        .wr_data (nxt_wd),
        .rd_addr (rd_addr),
        .rd_data (nxt_rd)
    );

    dlle_ram #(.WIDTH(IW), .DEPTH(MEM_DEPTH)) u_prev_link
    (
        .clk     (clk),
        .wr_en   (prv_we),
        .wr_addr (prv_wa),
        .wr_data (prv_wd),
        .rd_addr (rd_addr),
        .rd_data (prv_rd)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign walk_last = (CW'(walk_reg) == (count_reg - CW'(1)));
    // the one key comparator, shared by every step of the search
    assign key_match = (key_rd == key_reg);
    // free slot never used yet: its link is the next fresh slot
    assign is_fresh  = (CW'(node_reg) == fresh_reg);
    assign fresh_inc = fresh_reg + CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_INSERT:    state_next = is_full  ? S_EMIT : S_INS;
                        OP_DEL_KEY:   state_next = is_empty ? S_EMIT : S_WALK;
                        OP_DEL_FIRST: state_next = is_empty ? S_EMIT : S_UNLINK;
                        OP_DEL_LAST:  state_next = is_empty ? S_EMIT : S_UNLINK;
                        OP_READ:      state_next = is_empty ? S_EMIT : S_READ;
                        default:      state_next = S_EMIT;
                    endcase
                end
            end
            S_INS:     state_next = S_EMIT;
            S_WALK:
            begin
                priority if (key_match)
                    state_next = S_UNLINK;
                else if (walk_last)
                    state_next = S_EMIT;
                else
                    state_next = S_WALK;
            end
            S_UNLINK:  state_next = S_RELEASE;
            S_RELEASE: state_next = S_EMIT;
            S_READ:
            begin
                if (rsp_free && walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_addr        = node_reg;
        key_we         = 1'b0;
        nxt_we         = 1'b0;
        nxt_wa         = node_reg;
        nxt_wd         = head_reg;
        prv_we         = 1'b0;
        prv_wa         = head_reg;
        prv_wd         = node_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = cmd.key;
                    walk_next   = '0;
                    status_next = ST_OK;
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            rd_addr = free_head_reg;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_DEL_KEY, OP_DEL_FIRST, OP_READ:
                        begin
                            rd_addr = head_reg;
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        OP_DEL_LAST:
                        begin
                            rd_addr = tail_reg;
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            rd_addr = node_reg;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // new slot goes in front of the old head
                key_we = 1'b1;
                if (!is_empty)
                begin
                    prv_we = 1'b1;
                    nxt_we = 1'b1;
                end
                if (is_fresh)
                begin
                    free_head_next = IW'(fresh_inc);
                    fresh_next     = fresh_inc;
                end
                else
                begin
                    free_head_next = nxt_rd;
                end
                head_next = node_reg;
                if (is_empty)
                begin
                    tail_next = node_reg;
                end
                count_next = count_reg + CW'(1);
            end
            S_WALK:
            begin
                if (!key_match)
                begin
                    if (walk_last)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        walk_next = walk_reg + IW'(1);
                        rd_addr   = nxt_rd;
                    end
                end
            end
            S_UNLINK:
            begin
                priority if (count_reg == CW'(1))
                begin
                    // lone element: list becomes empty
                end
                else if (node_reg == head_reg)
                begin
                    head_next = nxt_rd;
                end
                else if (node_reg == tail_reg)
                begin
                    tail_next = prv_rd;
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = prv_rd;
                    nxt_wd = nxt_rd;
                    prv_we = 1'b1;
                    prv_wa = nxt_rd;
                    prv_wd = prv_rd;
                end
            end
            S_RELEASE:
            begin
                nxt_we         = 1'b1;
                nxt_wa         = node_reg;
                nxt_wd         = free_head_reg;
                free_head_next = node_reg;
                count_next     = count_reg - CW'(1);
            end
            S_READ:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = ST_OK;
                    rsp_next.key_out = key_rd;
                    rsp_next.count   = COUNT_W'(count_reg);
                    rsp_next.last    = walk_last;
                    if (!walk_last)
                    begin
                        walk_next = walk_reg + IW'(1);
                        rd_addr   = nxt_rd;
                    end
                end
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = status_reg;
                    rsp_next.key_out = '0;
                    rsp_next.count   = COUNT_W'(count_reg);
                    rsp_next.last    = 1'b1;
                end
            end
            default:
            begin
                rd_addr = node_reg;
            end
        endcase
    end

    // ram outputs always belong to the address read last cycle
    assign node_next = rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        walk_reg   <= walk_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count stays within the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // every live element sits in a slot taken from the fresh region
    a_fresh_cover: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg >= count_reg)
        else $error("fill mark below element count");

    // a result not marked last only shows during a read out walk
    a_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |-> (state_reg == S_READ))
        else $error("unfinished read out result outside walk");

    // the walk never runs past the end of the list
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_READ) |-> (CW'(walk_reg) < count_reg))
        else $error("walk beyond list end");

endmodule

### hw/rtl/dlle_ram.sv
`timescale 1ns / 1ps

// simple dual port ram, one write and one registered read per cycle
module dlle_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
